// ----- sv/positional_list_insert_delete_max_assert.svh -----
// Assertion macros for the positional list block checker.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MAX_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MAX_ASSERT_SVH

// Same-cycle implication, clocked by clk, off while rst_n is low.
`define PLM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked by clk, off while rst_n is low.
`define PLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/plm_pkg.sv -----
// Shared types and constants for the positional list block.
`default_nettype none

package plm_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int OCNT_W   = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        status_t                   status;
        logic [OCNT_W-1:0]         count;
        logic signed [DATA_W-1:0]  read_value;
        logic signed [DATA_W-1:0]  largest;
        logic                      largest_valid;
    } res_item_t;

    // control of the shared max unit
    typedef struct packed {
        logic load;
        logic feed;
    } max_ctl_t;

endpackage

`default_nettype wire

// ----- sv/plm_if.sv -----
// Command and result channel interfaces for the positional list block.
`default_nettype none

interface plm_cmd_if import plm_pkg::*;;
    logic                     valid;
    logic                     ready;
    cmd_t                     command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

interface plm_res_if import plm_pkg::*;;
    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic [OCNT_W-1:0]        count;
    logic signed [DATA_W-1:0] read_value;
    logic signed [DATA_W-1:0] largest;
    logic                     largest_valid;

    modport source (output valid, output status, output count, output read_value,
                    output largest, output largest_valid, input ready);
    modport sink   (input valid, input status, input count, input read_value,
                    input largest, input largest_valid, output ready);
endinterface

`default_nettype wire

// ----- sv/positional_list_insert_delete_max.sv -----
// Top level: positional list with insert, delete, clear, read and running max.
// One command at a time; n = count before the command, p = position.
// Insert shifts entries p..n-1 up one place and writes the new entry; delete shifts p+1..n-1
// down one place (each move is a RAM read then a write), then a max rescan.
// Clear and refused commands go straight to the result. Result register frees the input.
// rst_n (async, low) empties the list; entry storage is not cleared.
`default_nettype none

module positional_list_insert_delete_max import plm_pkg::*; (
    input wire logic   clk,
    input wire logic   rst_n,
    plm_cmd_if.sink    cmd,
    plm_res_if.source  res
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_MOVE_RD = 7'b0000010,
        S_MOVE_WR = 7'b0000100,
        S_PUT     = 7'b0001000,
        S_READ    = 7'b0010000,
        S_SCAN    = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     pend_reg, pend_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    status_t                  status_reg, status_next;
    logic                     rd_ok_reg, rd_ok_next;
    logic                     first_reg, first_next;
    res_item_t                out_reg, out_next;

    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         cnt_w;
    logic [CNT_W-1:0]         idx_dec;
    logic [CNT_W-1:0]         idx_inc;
    logic                     accept;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    max_ctl_t                 mctl;
    logic signed [DATA_W-1:0] mdata;
    logic signed [DATA_W-1:0] max_val;

    plm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    plm_max u_max (
        .clk     (clk),
        .ctl     (mctl),
        .data    (mdata),
        .max_val (max_val)
    );

    assign pos_w   = CMP_W'(cmd.position);
    assign cnt_w   = CMP_W'(count_reg);
    assign idx_dec = idx_reg - CNT_W'(1);
    assign idx_inc = idx_reg + CNT_W'(1);

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        rd_ok_next     = rd_ok_reg;
        first_next     = first_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = val_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        mctl           = '0;
        mdata          = '0;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd.command;
                    val_next    = cmd.value;
                    pos_next    = CNT_W'(pos_w);
                    status_next = ST_OK;
                    rd_ok_next  = 1'b0;
                    state_next  = S_DONE;
                    case (cmd.command)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_w > cnt_w)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_MOVE_RD;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next   = CNT_W'(pos_w);
                                state_next = S_MOVE_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_READ:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_MOVE_RD:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    // shift up from the top: entry idx-1 moves to idx
                    if (idx_reg > pos_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_dec[ADDR_W-1:0];
                        state_next = S_MOVE_WR;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    // shift down: entry idx+1 moves to idx
                    if (idx_inc < count_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_inc[ADDR_W-1:0];
                        state_next = S_MOVE_WR;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        first_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_MOVE_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[ADDR_W-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = (cmd_reg == CMD_INSERT) ? idx_dec : idx_inc;
                state_next = S_MOVE_RD;
            end

            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[ADDR_W-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                mdata      = val_reg;
                mctl.load  = (count_reg == '0);
                mctl.feed  = (count_reg != '0);
                state_next = S_DONE;
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = pos_reg[ADDR_W-1:0];
                rd_ok_next = 1'b1;
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                // read issued one cycle, compared the next
                if (pend_reg)
                begin
                    mdata      = ram_rdata;
                    mctl.load  = first_reg;
                    mctl.feed  = !first_reg;
                    first_next = 1'b0;
                end
                if (idx_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_inc;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_next.status        = status_reg;
                    out_next.count         = OCNT_W'(count_reg);
                    out_next.read_value    = rd_ok_reg ? ram_rdata : '0;
                    out_next.largest       = (count_reg != '0) ? max_val : '0;
                    out_next.largest_valid = (count_reg != '0);
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rd_ok_reg  <= rd_ok_next;
        first_reg  <= first_next;
        out_reg    <= out_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_reg.status;
    assign res.count         = out_reg.count;
    assign res.read_value    = out_reg.read_value;
    assign res.largest       = out_reg.largest;
    assign res.largest_valid = out_reg.largest_valid;

endmodule

`default_nettype wire

// ----- sv/plm_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module plm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/plm_max.sv -----
// Shared signed compare unit that tracks the running maximum.
`default_nettype none

module plm_max import plm_pkg::*; (
    input  wire logic                     clk,
    input  wire max_ctl_t                 ctl,
    input  wire logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0]      max_val
);

    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] max_next;
    logic                     gt;

    assign gt = data > max_reg;

    always_comb
    begin
        max_next = max_reg;
        if (ctl.load || (ctl.feed && gt))
        begin
            max_next = data;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
    end

    assign max_val = max_reg;

endmodule

`default_nettype wire

// ----- sv/plm_chk.sv -----
// Port-level assertion checker for the positional list block, with its bind.
`default_nettype none

`include "positional_list_insert_delete_max_assert.svh"

module plm_chk import plm_pkg::*; (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     cmd_valid,
    input wire logic                     cmd_ready,
    input wire logic                     res_valid,
    input wire logic                     res_ready,
    input wire status_t                  status,
    input wire logic [OCNT_W-1:0]        count,
    input wire logic signed [DATA_W-1:0] read_value,
    input wire logic signed [DATA_W-1:0] largest,
    input wire logic                     largest_valid
);

    `PLM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(status) && $stable(count) && $stable(read_value) && $stable(largest) && $stable(largest_valid), "result changed while stalled")
    `PLM_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "took a second item while busy")
    `PLM_ASSERT_SAME(a_valid_flag, res_valid, largest_valid == (count != '0), "largest_valid disagrees with count")
    `PLM_ASSERT_SAME(a_empty_zero, res_valid && !largest_valid, largest == '0 && read_value == '0, "empty list result not zero")
    `PLM_ASSERT_SAME(a_full_count, res_valid && status == ST_FULL, count == OCNT_W'(CAPACITY), "full status with list not full")

endmodule

bind positional_list_insert_delete_max plm_chk u_plm_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .status        (res.status),
    .count         (res.count),
    .read_value    (res.read_value),
    .largest       (res.largest),
    .largest_valid (res.largest_valid)
);

`default_nettype wire

// ----- tb/positional_list_insert_delete_max_tb.sv -----
// Positional list testbench: directed and random command stream, checked against a local list.
`timescale 1ns / 1ps

module positional_list_insert_delete_max_tb;
    import plm_pkg::*;

    localparam int ITEM_TOTAL   = 1300;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 500;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        cmd_t                     command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } list_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plm_cmd_if cmd_ch ();
    plm_res_if res_ch ();

    positional_list_insert_delete_max dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    list_cmd_t  pending_cmds [$];
    res_item_t  want_results [$];

    // local copy of the list
    logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
    int                       shadow_len = 0;

    int  gen_len = 0;        // count as the stimulus generator tracks it
    int  cmds_queued = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  cmd_fired = 1'b0;

    // works out the result of one command and updates the local list
    function automatic res_item_t apply_to_list(list_cmd_t c);
        res_item_t r;
        int        p;
        r = '0;
        r.status = ST_OK;
        p = c.position;
        case (c.command)
            CMD_INSERT:
            begin
                if (shadow_len >= CAPACITY)
                    r.status = ST_FULL;
                else if (p > shadow_len)
                    r.status = ST_BADPOS;
                else
                begin
                    for (int i = shadow_len; i > p; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[p] = c.value;
                    shadow_len++;
                end
            end
            CMD_DELETE:
            begin
                if (p >= shadow_len)
                    r.status = ST_BADPOS;
                else
                begin
                    for (int i = p; i + 1 < shadow_len; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                end
            end
            CMD_CLEAR:
                shadow_len = 0;
            default:
            begin
                if (p >= shadow_len)
                    r.status = ST_BADPOS;
                else
                    r.read_value = shadow_vals[p];
            end
        endcase
        r.count = shadow_len[OCNT_W-1:0];
        if (shadow_len > 0)
        begin
            r.largest = shadow_vals[0];
            for (int i = 1; i < shadow_len; i++)
                if (shadow_vals[i] > r.largest)
                    r.largest = shadow_vals[i];
            r.largest_valid = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(cmd_t c, int p, logic signed [DATA_W-1:0] v);
        list_cmd_t item;
        item.command  = c;
        item.position = p[POS_W-1:0];
        item.value    = v;
        pending_cmds.push_back(item);
        cmds_queued++;
        p = item.position;
        case (c)
            CMD_INSERT: if (gen_len < CAPACITY && p <= gen_len) gen_len++;
            CMD_DELETE: if (p < gen_len) gen_len--;
            CMD_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    // one random command, mostly at a live position
    task automatic queue_random(int ins_pct, int del_pct, int clr_pct);
        int   roll;
        bit   in_range;
        cmd_t c;
        int   p;
        roll = $urandom_range(0, 99);
        in_range = ($urandom_range(0, 9) != 0);
        if (roll < ins_pct)
            c = CMD_INSERT;
        else if (roll < ins_pct + del_pct)
            c = CMD_DELETE;
        else if (roll < ins_pct + del_pct + clr_pct)
            c = CMD_CLEAR;
        else
            c = CMD_READ;
        if (c == CMD_INSERT && in_range)
            p = $urandom_range(0, gen_len);
        else if (c != CMD_INSERT && in_range && gen_len > 0)
            p = $urandom_range(0, gen_len - 1);
        else
            p = $urandom_range(0, 255);
        queue_cmd(c, p, rand_value());
    endtask

    task automatic fill_list();
        while (gen_len < CAPACITY)
            queue_cmd(CMD_INSERT, $urandom_range(0, gen_len), rand_value());
        repeat ($urandom_range(1, 3))
            queue_cmd(CMD_INSERT, $urandom_range(0, 255), rand_value());
    endtask

    task automatic report_mismatch(string field, longint want, longint got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    initial
    begin
        int mode;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_INSERT;
        cmd_ch.position = '0;
        cmd_ch.value    = '0;
        res_ch.ready    = 1'b0;

        // corner cases on a fresh list
        queue_cmd(CMD_READ,   0, rand_value());
        queue_cmd(CMD_DELETE, 0, rand_value());
        queue_cmd(CMD_INSERT, 1, rand_value());
        queue_cmd(CMD_INSERT, 0, 32'sh7fff_ffff);
        queue_cmd(CMD_INSERT, 0, 32'sh8000_0000);
        queue_cmd(CMD_INSERT, 2, -32'sd1);
        queue_cmd(CMD_INSERT, 1, 32'sh0);
        queue_cmd(CMD_INSERT, 5, rand_value());
        for (int i = 0; i < 5; i++)
            queue_cmd(CMD_READ, i, rand_value());
        queue_cmd(CMD_READ,   255, rand_value());
        queue_cmd(CMD_DELETE, 3, rand_value());
        queue_cmd(CMD_DELETE, 0, rand_value());
        queue_cmd(CMD_DELETE, 200, rand_value());
        queue_cmd(CMD_READ,   0, rand_value());
        queue_cmd(CMD_CLEAR,  0, rand_value());
        queue_cmd(CMD_READ,   0, rand_value());
        queue_cmd(CMD_DELETE, 0, rand_value());
        queue_cmd(CMD_CLEAR,  255, rand_value());
        queue_cmd(CMD_INSERT, 0, -32'sd5);
        queue_cmd(CMD_INSERT, 1, -32'sd7);
        queue_cmd(CMD_DELETE, 0, rand_value());

        // full list early on, then its top end
        fill_list();
        queue_cmd(CMD_READ,   CAPACITY - 1, rand_value());
        queue_cmd(CMD_READ,   CAPACITY, rand_value());
        queue_cmd(CMD_DELETE, CAPACITY, rand_value());
        queue_cmd(CMD_DELETE, CAPACITY - 1, rand_value());

        while (cmds_queued < ITEM_TOTAL)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 9)
                fill_list();
            else
                repeat ($urandom_range(10, 60))
                begin
                    if (mode < 4)
                        queue_random(70, 10, 0);
                    else if (mode < 7)
                        queue_random(15, 65, 0);
                    else
                        queue_random(40, 30, 3);
                end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || want_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // command driver: bursts of items with gaps between
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!(cmd_ch.valid && !cmd_fired))
        begin
            cmd_fired = 1'b0;
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                         : $urandom_range(1, 12);
                gap_left = $urandom_range(0, 10);
            end
            if (burst_left > 0)
            begin
                if (pending_cmds.size() > 0)
                begin
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.command  <= pending_cmds[0].command;
                    cmd_ch.position <= pending_cmds[0].position;
                    cmd_ch.value    <= pending_cmds[0].value;
                    burst_left--;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
            else
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // accepted command: predict its result
    always @(posedge clk)
    begin
        list_cmd_t taken;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            taken = pending_cmds.pop_front();
            want_results.push_back(apply_to_list(taken));
            cmd_fired = 1'b1;
        end
    end

    // result receiver: stall pattern, plus one long hold-off to back up the block
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    int      sink_mode = 0;
    int      phase_left = 0;
    logic [15:0] stall_pat = 16'h1;

    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                sink_mode = $urandom_range(0, 2);
                stall_pat = 16'($urandom) | 16'h1;
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            case (sink_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= stall_pat[0];
                default: res_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (want_results.size() == 0)
            begin
                $display("%0t ns: result item with none expected, count %0d", $time,
                         res_ch.count);
                mismatches++;
            end
            else
            begin
                want = want_results.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", want.status, res_ch.status);
                if (res_ch.count !== want.count)
                    report_mismatch("count", want.count, res_ch.count);
                if (res_ch.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, res_ch.read_value);
                if (res_ch.largest !== want.largest)
                    report_mismatch("largest", want.largest, res_ch.largest);
                if (res_ch.largest_valid !== want.largest_valid)
                    report_mismatch("largest_valid", want.largest_valid,
                                    res_ch.largest_valid);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
